// ===== src/wsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame parser, the item queue and the
// result stage.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;
    localparam logic [3:0] LEN16_BYTES = 4'd2;
    localparam logic [3:0] LEN64_BYTES = 4'd8;
    localparam logic [2:0] KEY_BYTES = 3'd4;

    localparam logic [3:0] OP_TEXT = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING = 4'h9;

    localparam logic [1:0] CLASS_DATA = 2'd0;
    localparam logic [1:0] CLASS_TEXT = 2'd1;
    localparam logic [1:0] CLASS_PING = 2'd2;
    localparam logic [1:0] CLASS_CLOSE = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
        logic       empty;
    } wsd_item_t;

    function automatic logic [1:0] class_of(input logic [3:0] op);
        logic [1:0] cls;
        case (op)
            OP_TEXT:  cls = CLASS_TEXT;
            OP_PING:  cls = CLASS_PING;
            OP_CLOSE: cls = CLASS_CLOSE;
            default:  cls = CLASS_DATA;
        endcase
        return cls;
    endfunction

endpackage
`default_nettype wire

// ===== src/websocket_frame_deframer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Receive-side frame parser: one stream byte in, at most one payload result out.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle and sustains one byte per cycle
// while the queue is not full. A payload byte reaches the output through
// the queue: the parser queues it, and the result stage unmasks it into the
// output register. Header, length and key bytes produce no result; a
// frame with a zero-length payload produces one empty marker with tlast
// set. The queue between the parser and the result stage holds FIFO_DEPTH
// items, and the parser stalls only when that queue is full.
module websocket_frame_deframer_top #(
    parameter int unsigned FIFO_DEPTH = wsd_pkg::FIFO_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] payload_byte
    output logic            m_axis_tlast,
    output logic [7:0]      m_axis_tuser    // [3:0] frame_opcode, [4] final_fragment,
                                            // [6:5] message_class, [7] empty_frame
);
    import wsd_pkg::*;

    wsd_item_t push_item, head_item;
    logic      q_push, q_full, q_pop, q_empty;
    logic [3:0] opcode;
    logic       fin;
    logic [1:0] cls;
    logic       empty;

    wsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    wsd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (head_item)
    );

    wsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_opcode (opcode),
        .out_fin    (fin),
        .out_class  (cls),
        .out_last   (m_axis_tlast),
        .out_empty  (empty)
    );

    assign m_axis_tuser = {empty, cls, fin, opcode};

    property p_empty_marker;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && empty) |-> (m_axis_tlast && m_axis_tdata == 8'd0);
    endproperty
    assert property (p_empty_marker)
        else $error("Empty frame marker without tlast or with nonzero data.");

    property p_class_text;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((opcode == OP_TEXT) == (cls == CLASS_TEXT));
    endproperty
    assert property (p_class_text)
        else $error("Message class does not match the text opcode.");

    property p_class_other;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && opcode != OP_TEXT && opcode != OP_PING && opcode != OP_CLOSE)
            |-> (cls == CLASS_DATA);
    endproperty
    assert property (p_class_other)
        else $error("Nonzero message class for a data or reserved opcode.");

    property p_no_push_when_full;
        @(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push;
    endproperty
    assert property (p_no_push_when_full)
        else $error("Parser pushed an item into a full queue.");

endmodule
`default_nettype wire

// ===== src/wsd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Parses header, extended length and masking key, and queues one item per
// payload byte or per empty frame.
// ----------------------------------------------------------------------------
module wsd_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         in_byte,
    input  wire logic               q_full,
    output logic                    q_push,
    output wsd_pkg::wsd_item_t      q_item
);
    import wsd_pkg::*;

    typedef enum logic [4:0] {
        PH_FIRST  = 5'b00001,
        PH_SECOND = 5'b00010,
        PH_EXTLEN = 5'b00100,
        PH_KEY    = 5'b01000,
        PH_DATA   = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  header_reg, header_next;
    logic [63:0] remain_reg, remain_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic        masked_reg, masked_next;
    logic [31:0] key_reg, key_next;
    logic [2:0]  key_left_reg, key_left_next;
    logic [1:0]  key_idx_reg, key_idx_next;

    logic        accept;
    logic [63:0] len_shift;
    logic [3:0]  len_dec;
    logic [2:0]  key_dec;
    logic [7:0]  key_byte;
    logic        last_byte;

    assign in_ready = !q_full;
    assign accept = in_valid && in_ready;
    assign len_shift = {remain_reg[55:0], in_byte};
    assign len_dec = (len_left_reg != 4'd0) ? len_left_reg - 4'd1 : 4'd0;
    assign key_dec = (key_left_reg != 3'd0) ? key_left_reg - 3'd1 : 3'd0;
    assign last_byte = (remain_reg[63:1] == 63'd0);

    always_comb
    begin
        case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        header_next = header_reg;
        remain_next = remain_reg;
        len_left_next = len_left_reg;
        masked_next = masked_reg;
        key_next = key_reg;
        key_left_next = key_left_reg;
        key_idx_next = key_idx_reg;
        q_push = 1'b0;
        q_item.data = 8'd0;
        q_item.key = 8'd0;
        q_item.opcode = header_reg[3:0];
        q_item.fin = header_reg[7];
        q_item.last = 1'b1;
        q_item.empty = 1'b1;
        if (accept)
        begin
            case (phase_reg)
                PH_SECOND:
                begin
                    masked_next = in_byte[7];
                    if (in_byte[6:0] == LEN16_CODE || in_byte[6:0] == LEN64_CODE)
                    begin
                        remain_next = 64'd0;
                        len_left_next = (in_byte[6:0] == LEN16_CODE) ? LEN16_BYTES
                                                                      : LEN64_BYTES;
                        phase_next = PH_EXTLEN;
                    end
                    else
                    begin
                        remain_next = {57'd0, in_byte[6:0]};
                        key_idx_next = 2'd0;
                        if (in_byte[7])
                        begin
                            key_next = 32'd0;
                            key_left_next = KEY_BYTES;
                            phase_next = PH_KEY;
                        end
                        else if (in_byte[6:0] == 7'd0)
                        begin
                            q_push = 1'b1;
                            phase_next = PH_FIRST;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_EXTLEN:
                begin
                    remain_next = len_shift;
                    len_left_next = len_dec;
                    key_idx_next = 2'd0;
                    if (len_dec == 4'd0)
                    begin
                        if (masked_reg)
                        begin
                            key_next = 32'd0;
                            key_left_next = KEY_BYTES;
                            phase_next = PH_KEY;
                        end
                        else if (len_shift == 64'd0)
                        begin
                            q_push = 1'b1;
                            phase_next = PH_FIRST;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], in_byte};
                    key_left_next = key_dec;
                    key_idx_next = 2'd0;
                    if (key_dec == 3'd0)
                    begin
                        if (remain_reg == 64'd0)
                        begin
                            q_push = 1'b1;
                            phase_next = PH_FIRST;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    q_push = 1'b1;
                    q_item.data = in_byte;
                    q_item.key = masked_reg ? key_byte : 8'd0;
                    q_item.last = last_byte;
                    q_item.empty = 1'b0;
                    remain_next = remain_reg - 64'd1;
                    key_idx_next = key_idx_reg + 2'd1;
                    if (last_byte)
                    begin
                        phase_next = PH_FIRST;
                    end
                end
                default:
                begin
                    header_next = in_byte;
                    phase_next = PH_SECOND;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            header_reg <= 8'd0;
            remain_reg <= 64'd0;
            len_left_reg <= 4'd0;
            masked_reg <= 1'b0;
            key_reg <= 32'd0;
            key_left_reg <= 3'd0;
            key_idx_reg <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            header_reg <= header_next;
            remain_reg <= remain_next;
            len_left_reg <= len_left_next;
            masked_reg <= masked_next;
            key_reg <= key_next;
            key_left_reg <= key_left_next;
            key_idx_reg <= key_idx_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/wsd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer item queue
// Short first-in first-out buffer between the parser and the result stage.
// ----------------------------------------------------------------------------
module wsd_fifo #(
    parameter int unsigned DEPTH = wsd_pkg::FIFO_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire wsd_pkg::wsd_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    empty,
    output wsd_pkg::wsd_item_t      head_item
);
    import wsd_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    wsd_item_t     mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full = (count_reg == FULL_COUNT);
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign head_item = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/wsd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket deframer result stage
// Unmasks queued bytes, derives the message class and holds the result in an
// output register.
// ----------------------------------------------------------------------------
module wsd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire wsd_pkg::wsd_item_t q_item,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_byte,
    output logic [3:0]              out_opcode,
    output logic                    out_fin,
    output logic [1:0]              out_class,
    output logic                    out_last,
    output logic                    out_empty
);
    import wsd_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [3:0] opcode_reg;
    logic       fin_reg;
    logic [1:0] class_reg;
    logic       last_reg;
    logic       empty_reg;

    assign q_pop = !q_empty && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            byte_reg <= q_item.data ^ q_item.key;
            opcode_reg <= q_item.opcode;
            fin_reg <= q_item.fin;
            class_reg <= class_of(q_item.opcode);
            last_reg <= q_item.last;
            empty_reg <= q_item.empty;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte = byte_reg;
    assign out_opcode = opcode_reg;
    assign out_fin = fin_reg;
    assign out_class = class_reg;
    assign out_last = last_reg;
    assign out_empty = empty_reg;

endmodule
`default_nettype wire
